[sv/dnss_pkg.sv]
`timescale 1ns / 1ps

package dnss_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [63:0]         MASKS_RESET  = 64'h0000_0000_F288_2824;
    localparam logic [LEN_BITS-1:0] LENGTH_RESET = LEN_BITS'(8);
    localparam logic [LEN_BITS-1:0] NICK_RESET   = LEN_BITS'(8);

    // register indexes on the config port (64-bit registers, 8-byte stride)
    typedef enum logic [1:0] {
        REG_MASKS  = 2'd0,
        REG_LENGTH = 2'd1,
        REG_NICK   = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [3:0] MASK_N = 4'hF;

    // base mask: bit0 A, bit1 C, bit2 G, bit3 T
    function automatic logic [3:0] char_mask(input logic [7:0] c);
        logic [3:0] m;
        case (c)
            8'h41, 8'h61: m = 4'b0001;
            8'h43, 8'h63: m = 4'b0010;
            8'h47, 8'h67: m = 4'b0100;
            8'h54, 8'h74: m = 4'b1000;
            default:      m = 4'b0000;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] comp_mask(input logic [3:0] m);
        return {m[0], m[1], m[2], m[3]};
    endfunction

    function automatic logic base_ok(input logic [3:0] want, input logic [3:0] have);
        return (want == MASK_N) || ((want & have) != 4'b0000);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

[sv/dna_nick_site_scanner_unit.sv]
`timescale 1ns / 1ps

// An accepted base passes the window/counter update register, then the parallel
// pattern compare into the output register that drives the master side.
// Throughput: one word per cycle; the slave side stalls only while the output
// register is full and not taken. Synchronous active-low reset restores the
// default pattern, length 8, nick 8, and clears window, base count and fill.
module dna_nick_site_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tuser,   // [0] command (1 = record start)
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] site_position
    output logic        m_axis_tuser,   // [0] reverse_strand
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LB = dnss_pkg::LEN_BITS;
    localparam int IB = dnss_pkg::IDX_BITS;
    localparam int MP = dnss_pkg::MAX_PATTERN;
    localparam int PB = dnss_pkg::POSITION_BITS;

    logic [63:0]   r_masks;
    logic [LB-1:0] r_length;
    logic [LB-1:0] r_nick;

    logic [3:0]    r_window [MP];
    logic [PB-1:0] r_count;
    logic [LB-1:0] r_fill;
    logic          r_chk_valid;

    logic          r_out_valid;
    logic [31:0]   r_out_site;
    logic          r_out_rev;

    logic              cfg_wr;
    dnss_pkg::t_reg_idx cfg_idx;
    logic          s_acc;
    logic          out_free;
    logic          is_base;

    logic [LB-1:0] len_eff;
    logic [LB-1:0] n_tap;
    logic          fwd_ok;
    logic          rev_ok;
    logic          self_rc;
    logic          hit;
    logic [PB-1:0] n_site;
    logic [3:0]    pat    [MP];
    logic [3:0]    have_f [MP];

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = dnss_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            dnss_pkg::REG_MASKS:  prdata = r_masks;
            dnss_pkg::REG_LENGTH: prdata = 64'(r_length);
            dnss_pkg::REG_NICK:   prdata = 64'(r_nick);
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks  <= dnss_pkg::MASKS_RESET;
            r_length <= dnss_pkg::LENGTH_RESET;
            r_nick   <= dnss_pkg::NICK_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dnss_pkg::REG_MASKS:  r_masks  <= pwdata;
                dnss_pkg::REG_LENGTH: r_length <= pwdata[LB-1:0];
                dnss_pkg::REG_NICK:   r_nick   <= pwdata[LB-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_chk_valid || out_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_base       = !s_axis_tuser && !dnss_pkg::is_space(s_axis_tdata);

    // ---------------- stage 1: window, count, fill ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MP; k++) begin
                r_window[k] <= 4'b0000;
            end
            r_count     <= '0;
            r_fill      <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_chk_valid <= is_base;
            end else if (out_free) begin
                r_chk_valid <= 1'b0;
            end
            if (s_acc) begin
                if (s_axis_tuser) begin
                    for (int k = 0; k < MP; k++) begin
                        r_window[k] <= 4'b0000;
                    end
                    r_count <= '0;
                    r_fill  <= '0;
                end else if (is_base) begin
                    for (int k = MP - 1; k > 0; k--) begin
                        r_window[k] <= r_window[k-1];
                    end
                    r_window[0] <= dnss_pkg::char_mask(s_axis_tdata);
                    r_count     <= r_count + PB'(1);
                    if (r_fill < LB'(MP)) begin
                        r_fill <= r_fill + LB'(1);
                    end
                end
            end
        end
    end

    // ---------------- stage 2: pattern compare ----------------
    always_comb begin
        if (r_length == '0) begin
            len_eff = LB'(1);
        end else if (r_length > LB'(MP)) begin
            len_eff = LB'(MP);
        end else begin
            len_eff = r_length;
        end
    end

    always_comb begin
        for (int k = 0; k < MP; k++) begin
            pat[k] = r_masks[4*k +: 4];
        end
    end

    // pattern position i meets window slot len-1-i (window newest at slot 0)
    always_comb begin
        fwd_ok  = 1'b1;
        rev_ok  = 1'b1;
        self_rc = 1'b1;
        for (int i = 0; i < MP; i++) begin
            n_tap     = len_eff - LB'(1) - LB'(i);
            have_f[i] = r_window[n_tap[IB-1:0]];
            if (LB'(i) < len_eff) begin
                if (!dnss_pkg::base_ok(pat[i], have_f[i])) begin
                    fwd_ok = 1'b0;
                end
                if (dnss_pkg::comp_mask(pat[n_tap[IB-1:0]]) != pat[i]) begin
                    self_rc = 1'b0;
                end
                // reverse: complement of pattern slot j against window slot j
                if (!dnss_pkg::base_ok(dnss_pkg::comp_mask(pat[i]), r_window[i])) begin
                    rev_ok = 1'b0;
                end
            end
        end
    end

    assign hit = (r_fill >= len_eff) && (fwd_ok || (!self_rc && rev_ok));

    always_comb begin
        if (fwd_ok) begin
            n_site = r_count - PB'(len_eff) + PB'(r_nick);
        end else begin
            n_site = r_count - PB'(r_nick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_chk_valid && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_chk_valid && hit) begin
            r_out_site <= 32'(n_site);
            r_out_rev  <= !fwd_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_site;
    assign m_axis_tuser  = r_out_rev;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LB'(MP))
        else $error("window fill above pattern depth");

    a_record_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tuser |=> (r_count == '0) && (r_fill == '0) && !r_chk_valid)
        else $error("record start did not clear position");

    a_space_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !s_axis_tuser && dnss_pkg::is_space(s_axis_tdata) |=> $stable(r_count))
        else $error("whitespace changed base count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid && !out_free |=> r_chk_valid && $stable(r_count))
        else $error("compare stage lost a word under back-pressure");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_WORDS = 118;

    localparam bit CMD_BASE   = 1'b0;
    localparam bit CMD_RECORD = 1'b1;

    typedef struct packed {
        logic [31:0] pos;
        logic        rev;
    } t_site;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = 5'd0;
    logic [63:0] pwdata        = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    dna_nick_site_scanner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] character
        .s_axis_tuser  (s_axis_tuser),   // [0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] site_position
        .m_axis_tuser  (m_axis_tuser),   // [0] reverse_strand
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // scanner shadow: config and per-record state
    logic [63:0] pat_masks;
    logic [4:0]  pat_len;
    logic [4:0]  nick;
    logic [3:0]  win [16];
    logic [31:0] bases_seen;
    logic [4:0]  fill;
    t_site       site_q [$];

    int  n_words   = 0;
    int  n_records = 0;
    int  n_fwd     = 0;
    int  n_rev     = 0;
    int  n_err     = 0;
    int  n_configs = 0;
    int  cycles    = 0;
    bit  gap_on    = 1'b1;
    bit  stall_on  = 1'b1;
    bit  out_taken = 1'b0;
    int  stall_left = 0;
    t_site want_site;

    task automatic report_err(string what, logic [63:0] got, logic [63:0] exp);
        n_err++;
        $display("mismatch %0d: %s got %0h expected %0h", n_err, what, got, exp);
    endtask

    function automatic logic [3:0] base_code(logic [7:0] c);
        case (c)
            "A", "a": return 4'b0001;
            "C", "c": return 4'b0010;
            "G", "g": return 4'b0100;
            "T", "t": return 4'b1000;
            default:  return 4'b0000;
        endcase
    endfunction

    function automatic logic [3:0] swap_strand(logic [3:0] m);
        logic [3:0] r;
        for (int k = 0; k < 4; k++) r[k] = m[3-k];
        return r;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == dnss_pkg::CH_SPACE || c == dnss_pkg::CH_TAB ||
               c == dnss_pkg::CH_CR || c == dnss_pkg::CH_LF;
    endfunction

    function automatic bit base_fits(logic [3:0] want, logic [3:0] have);
        return want == dnss_pkg::MASK_N || (want & have) != 4'b0000;
    endfunction

    function automatic logic [3:0] nib(int i);
        return pat_masks[i*4 +: 4];
    endfunction

    function automatic int eff_len();
        if (pat_len == 0) return 1;
        if (pat_len > dnss_pkg::MAX_PATTERN) return dnss_pkg::MAX_PATTERN;
        return int'(pat_len);
    endfunction

    function automatic void clear_record();
        for (int k = 0; k < 16; k++) win[k] = 4'b0000;
        bases_seen = 32'd0;
        fill = 5'd0;
    endfunction

    function automatic void scan_word(bit cmd, logic [7:0] ch);
        int len;
        bit fwd, rev, pal;
        logic [3:0] have, want, rc;
        if (cmd == CMD_RECORD) begin
            clear_record();
            n_records++;
            return;
        end
        if (is_blank(ch)) return;
        for (int k = 15; k > 0; k--) win[k] = win[k-1];
        win[0] = base_code(ch);
        bases_seen = bases_seen + 32'd1;
        if (fill < dnss_pkg::MAX_PATTERN) fill = fill + 5'd1;
        len = eff_len();
        if (fill < len) return;
        fwd = 1'b1;
        rev = 1'b1;
        pal = 1'b1;
        for (int i = 0; i < len; i++) begin
            have = win[len-1-i];
            want = nib(i);
            rc = swap_strand(nib(len-1-i));
            if (!base_fits(want, have)) fwd = 1'b0;
            if (rc != want) pal = 1'b0;
            if (!base_fits(rc, have)) rev = 1'b0;
        end
        if (fwd) begin
            site_q.push_back('{pos: bases_seen - 32'(len) + 32'(nick), rev: 1'b0});
            n_fwd++;
        end else if (!pal && rev) begin
            site_q.push_back('{pos: bases_seen - 32'(nick), rev: 1'b1});
            n_rev++;
        end
    endfunction

    // one word on the slave side; returns right after the accepting edge
    task automatic send_word(bit cmd, logic [7:0] ch);
        int gap;
        gap = gap_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        scan_word(cmd, ch);
        if (!(cmd == CMD_BASE && is_blank(ch))) n_words++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(CMD_BASE, s[i]);
    endtask

    // stop sending, let every expected site arrive, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (site_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic apb_write(dnss_pkg::t_reg_idx idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        case (idx)
            dnss_pkg::REG_MASKS:  pat_masks = v;
            dnss_pkg::REG_LENGTH: pat_len   = v[4:0];
            dnss_pkg::REG_NICK:   nick      = v[4:0];
            default:    ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(dnss_pkg::t_reg_idx idx);
        logic [63:0] exp;
        case (idx)
            dnss_pkg::REG_MASKS:  exp = pat_masks;
            dnss_pkg::REG_LENGTH: exp = 64'(pat_len);
            default:    exp = 64'(nick);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        if (prdata !== exp)
            report_err($sformatf("register %s readback", idx.name()), prdata, exp);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_all();
        apb_read(dnss_pkg::REG_MASKS);
        apb_read(dnss_pkg::REG_LENGTH);
        apb_read(dnss_pkg::REG_NICK);
    endtask

    function automatic logic [7:0] letter(int k, bit lower);
        logic [7:0] c;
        case (k)
            0:       c = "A";
            1:       c = "C";
            2:       c = "G";
            default: c = "T";
        endcase
        return lower ? (c | 8'h20) : c;
    endfunction

    // any byte that is neither a base letter nor whitespace
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom); while (is_blank(c) || base_code(c) != 4'b0000);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return dnss_pkg::CH_SPACE;
            1:       return dnss_pkg::CH_TAB;
            2:       return dnss_pkg::CH_CR;
            default: return dnss_pkg::CH_LF;
        endcase
    endfunction

    // a character that satisfies one pattern position
    function automatic logic [7:0] char_for(logic [3:0] m);
        int k;
        if (m == 4'b0000 || (m == dnss_pkg::MASK_N && $urandom_range(0, 3) == 0))
            return noise_char();
        do k = $urandom_range(0, 3); while (!m[k]);
        return letter(k, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_site(bit rc);
        int len;
        logic [3:0] m;
        len = eff_len();
        for (int i = 0; i < len; i++) begin
            m = rc ? swap_strand(nib(len-1-i)) : nib(i);
            if ($urandom_range(0, 19) == 0) send_word(CMD_BASE, blank_char());
            send_word(CMD_BASE, char_for(m));
        end
    endtask

    task automatic random_config(int p);
        logic [63:0] m;
        logic [4:0]  lv, nv;
        int el;
        for (int i = 0; i < 16; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: m[i*4 +: 4] = 4'b0001 << $urandom_range(0, 3);
                4, 5:       m[i*4 +: 4] = dnss_pkg::MASK_N;
                6, 7:       m[i*4 +: 4] = (4'b0001 << $urandom_range(0, 3))
                                        | (4'b0001 << $urandom_range(0, 3));
                8:          m[i*4 +: 4] = 4'b0000;
                default:    m[i*4 +: 4] = 4'($urandom);
            endcase
        end
        case (p % 6)
            0:       lv = 5'd1;
            1:       lv = 5'd16;
            2:       lv = 5'd0;
            3:       lv = 5'($urandom_range(17, 31));
            default: lv = 5'($urandom_range(2, 15));
        endcase
        el = (lv == 0) ? 1 : (lv > 16) ? 16 : int'(lv);
        // sometimes a pattern that reads the same on both strands
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < el / 2; i++) m[(el-1-i)*4 +: 4] = swap_strand(m[i*4 +: 4]);
            if (el % 2 == 1) begin
                case ($urandom_range(0, 3))
                    0:       m[(el/2)*4 +: 4] = dnss_pkg::MASK_N;
                    1:       m[(el/2)*4 +: 4] = 4'b0110;
                    2:       m[(el/2)*4 +: 4] = 4'b1001;
                    default: m[(el/2)*4 +: 4] = 4'b0000;
                endcase
            end
        end
        case ($urandom_range(0, 5))
            0:       nv = 5'd0;
            1:       nv = 5'd16;
            2:       nv = 5'd31;
            default: nv = 5'($urandom_range(0, el));
        endcase
        apb_write(dnss_pkg::REG_MASKS, m);
        apb_write(dnss_pkg::REG_LENGTH, {$urandom, $urandom} & ~64'h1F | 64'(lv));
        apb_write(dnss_pkg::REG_NICK, {$urandom, $urandom} & ~64'h1F | 64'(nv));
        if ($urandom_range(0, 2) == 0) apb_write(dnss_pkg::REG_NONE, {$urandom, $urandom});
        read_all();
        n_configs++;
    endtask

    task automatic test_defaults();
        read_all();
        send_word(CMD_RECORD, 8'hFF);
        send_text("gctcttcA");        // forward site
        send_text("xGAAG AGC");       // reverse strand, non-base under the N position
        n_configs++;
    endtask

    task automatic test_config_extremes();
        drain();
        apb_write(dnss_pkg::REG_MASKS, 64'hFFFF_FFFF_FFFF_FFF4);
        apb_write(dnss_pkg::REG_LENGTH, 64'd0);          // acts as length one
        apb_write(dnss_pkg::REG_NICK, 64'd31);           // nick past the pattern end
        apb_write(dnss_pkg::REG_NONE, 64'hDEAD_BEEF_0123_4567);
        read_all();
        send_word(CMD_RECORD, 8'h00);
        send_text("gC?");                      // reverse site wraps below zero
        drain();
        apb_write(dnss_pkg::REG_MASKS, 64'd0);           // own reverse complement, never matches
        apb_write(dnss_pkg::REG_LENGTH, 64'd1);
        apb_write(dnss_pkg::REG_NICK, 64'd16);
        read_all();
        send_text("AN");
        n_configs += 2;
    endtask

    task automatic test_random_phase(int p);
        int target;
        int r;
        bit paused;
        drain();
        random_config(p);
        gap_on   = (p % 4 == 1) ? 1'b0 : $urandom_range(0, 3) != 0;
        stall_on = (p % 4 == 1) ? 1'b0 : $urandom_range(0, 3) != 0;
        paused   = 1'b0;
        target   = n_words + PHASE_WORDS;
        if ($urandom_range(0, 1)) send_word(CMD_RECORD, 8'($urandom));
        while (n_words < target) begin
            if (p == 3 && !paused && n_words >= target - PHASE_WORDS / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                send_site(1'($urandom_range(0, 1)));
            else if (r < 80)
                repeat ($urandom_range(1, 6))
                    send_word(CMD_BASE,
                              letter($urandom_range(0, 3), 1'($urandom_range(0, 1))));
            else if (r < 88)
                send_word(CMD_BASE, blank_char());
            else if (r < 96)
                send_word(CMD_BASE, 8'($urandom));
            else
                send_word(CMD_RECORD, 8'($urandom));
        end
    endtask

    // result side: handshake is decided by values that settle before the edge
    always @(negedge i_clk) begin
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken) begin
            if (site_q.size() == 0) begin
                report_err("site word with none pending",
                           64'({m_axis_tuser, m_axis_tdata}), 64'd0);
            end else begin
                want_site = site_q.pop_front();
                if (m_axis_tdata !== want_site.pos)
                    report_err("site_position", 64'(m_axis_tdata), 64'(want_site.pos));
                if (m_axis_tuser !== want_site.rev)
                    report_err("reverse_strand", 64'(m_axis_tuser), 64'(want_site.rev));
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_taken)
            stall_left = stall_on ? $urandom_range(0, 14) : 0;
        else if (stall_left > 0)
            stall_left--;
        m_axis_tready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        pat_masks = dnss_pkg::MASKS_RESET;
        pat_len   = dnss_pkg::LENGTH_RESET;
        nick      = dnss_pkg::NICK_RESET;
        clear_record();
        @(posedge i_clk);

        test_defaults();
        test_config_extremes();
        for (int p = 0; p < N_PHASES; p++) test_random_phase(p);
        drain();

        $display("run: %0d words in %0d records over %0d pattern settings",
                 n_words, n_records, n_configs);
        $display("run: %0d forward and %0d reverse sites checked", n_fwd, n_rev);
        if (n_err == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
